// File: design/dmdb_pkg.sv
package dmdb_pkg;

  localparam int TIME_WIDTH   = 48;
  localparam int SAMPLE_BITS  = 12;
  localparam int SAMPLE_MAX   = 4095;
  localparam int DUTY_BITS    = 10;
  localparam int DUTY_MAX     = 1023;
  localparam int PERIOD_BITS  = 14;
  localparam int DEBOUNCE_BITS = 20;
  localparam int HALF_BITS    = 23;
  localparam int HALF_SCALE   = 500;
  localparam int QUOT_IN_BITS = 26;

  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [1:0] REG_DEBOUNCE_TIME = 2'd0;
  localparam logic [1:0] REG_MIN_PERIOD_MS = 2'd1;
  localparam logic [1:0] REG_MAX_PERIOD_MS = 2'd2;

  localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 20'd50000;
  localparam logic [PERIOD_BITS-1:0]   MIN_PERIOD_RESET = 14'd100;
  localparam logic [PERIOD_BITS-1:0]   MAX_PERIOD_RESET = 14'd1000;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]  now_us;
    logic                   button_level;
    logic [SAMPLE_BITS-1:0] pot_sample;
    logic [SAMPLE_BITS-1:0] light_sample;
  } poll_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0]   duty;
    logic                   blink_level;
    logic                   mode;
    logic [SAMPLE_BITS-1:0] selected_sample;
  } result_t;

  typedef struct packed {
    logic [DEBOUNCE_BITS-1:0] debounce_time;
    logic [PERIOD_BITS-1:0]   min_period_ms;
    logic [PERIOD_BITS-1:0]   max_period_ms;
  } cfg_t;

  // per-poll values worked out for both samples ahead of the state update
  typedef struct packed {
    logic [TIME_WIDTH-1:0]  now_us;
    logic                   button_level;
    logic [SAMPLE_BITS-1:0] pot_sample;
    logic [SAMPLE_BITS-1:0] light_sample;
    logic [DUTY_BITS-1:0]   duty_pot;
    logic [DUTY_BITS-1:0]   duty_light;
    logic [HALF_BITS-1:0]   half_pot;
    logic [HALF_BITS-1:0]   half_light;
  } pre_t;

  // x / (2^12 - 1) by folding: x = a*4096 + b = a*4095 + (a + b)
  function automatic logic [PERIOD_BITS:0] div_sample_max(input logic [QUOT_IN_BITS-1:0] x);
    logic [QUOT_IN_BITS-SAMPLE_BITS-1:0] a;
    logic [QUOT_IN_BITS-SAMPLE_BITS:0]   s1;
    logic [2:0]                          a2;
    logic [SAMPLE_BITS:0]                s2;
    a  = x[QUOT_IN_BITS-1:SAMPLE_BITS];
    s1 = {1'b0, a} + (QUOT_IN_BITS - SAMPLE_BITS + 1)'(x[SAMPLE_BITS-1:0]);
    a2 = s1[QUOT_IN_BITS-SAMPLE_BITS:SAMPLE_BITS];
    s2 = {1'b0, s1[SAMPLE_BITS-1:0]} + (SAMPLE_BITS + 1)'(a2);
    return (PERIOD_BITS + 1)'(a) + (PERIOD_BITS + 1)'(a2)
         + (PERIOD_BITS + 1)'(s2 >= (SAMPLE_BITS + 1)'(SAMPLE_MAX));
  endfunction

endpackage

// File: design/debounced_mode_dimmer_blinker.sv
// Debounced two-mode dimmer with a variable-rate blinker.
// poll channel: one beat per poll carries now_us, the raw button level
// (0 pressed) and the pot and light samples. result channel: one beat per
// poll with duty, blink level, mode and the selected sample. A beat moves
// at a clock edge where valid is high and stall is low.
// Registers sit on the APB port at byte addresses 0 (debounce_time),
// 4 (min_period_ms) and 8 (max_period_ms); write them only while idle.
// A poll that is taken passes the input, multiply and divide registers and
// then the result register. Throughput is one poll per cycle while the
// result side does not stall; the limit is the debounce and blink state
// update, which must finish before the next poll. When the result side
// stalls, the held result and the three pipeline stages in front of it
// fill up, and only then is stall raised on the poll channel. Reset empties
// the pipeline, restores the register defaults, sets the accepted level to
// released, mode to manual, blink off and both timestamps to zero.
module debounced_mode_dimmer_blinker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            poll_valid,
  output logic                            poll_stall,
  input  dmdb_pkg::poll_t                 poll,
  output logic                            result_valid,
  input  logic                            result_stall,
  output dmdb_pkg::result_t               result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dmdb_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [dmdb_pkg::DATA_BITS-1:0]  pwdata,
  output logic [dmdb_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready
);

  dmdb_pkg::cfg_t cfg;
  dmdb_pkg::pre_t pre;
  logic           pre_valid;
  logic           pre_ready;

  dmdb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dmdb_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .poll_valid (poll_valid),
    .poll_stall (poll_stall),
    .poll       (poll),
    .pre_valid  (pre_valid),
    .pre_ready  (pre_ready),
    .pre        (pre)
  );

  dmdb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pre_valid    (pre_valid),
    .pre_ready    (pre_ready),
    .pre          (pre),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: design/dmdb_regs.sv
module dmdb_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dmdb_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [dmdb_pkg::DATA_BITS-1:0]  pwdata,
  output logic [dmdb_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready,
  output dmdb_pkg::cfg_t                  cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time <= dmdb_pkg::DEBOUNCE_RESET;
      cfg.min_period_ms <= dmdb_pkg::MIN_PERIOD_RESET;
      cfg.max_period_ms <= dmdb_pkg::MAX_PERIOD_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        dmdb_pkg::REG_DEBOUNCE_TIME: begin
          cfg.debounce_time <= pwdata[dmdb_pkg::DEBOUNCE_BITS-1:0];
        end
        dmdb_pkg::REG_MIN_PERIOD_MS: begin
          cfg.min_period_ms <= pwdata[dmdb_pkg::PERIOD_BITS-1:0];
        end
        dmdb_pkg::REG_MAX_PERIOD_MS: begin
          cfg.max_period_ms <= pwdata[dmdb_pkg::PERIOD_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      dmdb_pkg::REG_DEBOUNCE_TIME: prdata = dmdb_pkg::DATA_BITS'(cfg.debounce_time);
      dmdb_pkg::REG_MIN_PERIOD_MS: prdata = dmdb_pkg::DATA_BITS'(cfg.min_period_ms);
      dmdb_pkg::REG_MAX_PERIOD_MS: prdata = dmdb_pkg::DATA_BITS'(cfg.max_period_ms);
      default:                     prdata = '0;
    endcase
  end

endmodule

// File: design/dmdb_scale.sv
module dmdb_scale (
  input  logic            clk,
  input  logic            rst,
  input  dmdb_pkg::cfg_t  cfg,
  input  logic            poll_valid,
  output logic            poll_stall,
  input  dmdb_pkg::poll_t poll,
  output logic            pre_valid,
  input  logic            pre_ready,
  output dmdb_pkg::pre_t  pre
);

  localparam int PROD_BITS = dmdb_pkg::SAMPLE_BITS + dmdb_pkg::PERIOD_BITS + 2;
  localparam int DPROD_BITS = dmdb_pkg::SAMPLE_BITS + dmdb_pkg::DUTY_BITS;

  typedef struct packed {
    logic [dmdb_pkg::TIME_WIDTH-1:0]  now_us;
    logic                             button_level;
    logic [dmdb_pkg::SAMPLE_BITS-1:0] pot_sample;
    logic [dmdb_pkg::SAMPLE_BITS-1:0] light_sample;
    logic signed [PROD_BITS-1:0]      prod_pot;
    logic signed [PROD_BITS-1:0]      prod_light;
  } mul_t;

  typedef struct packed {
    logic [dmdb_pkg::TIME_WIDTH-1:0]  now_us;
    logic                             button_level;
    logic [dmdb_pkg::SAMPLE_BITS-1:0] pot_sample;
    logic [dmdb_pkg::SAMPLE_BITS-1:0] light_sample;
    logic [dmdb_pkg::DUTY_BITS-1:0]   duty_pot;
    logic [dmdb_pkg::DUTY_BITS-1:0]   duty_light;
    logic [dmdb_pkg::PERIOD_BITS-1:0] period_pot;
    logic [dmdb_pkg::PERIOD_BITS-1:0] period_light;
  } div_t;

  dmdb_pkg::poll_t in_q;
  mul_t            mul_q;
  div_t            div_q;
  logic            in_v;
  logic            mul_v;
  logic            div_v;
  logic            in_ready;
  logic            mul_ready;
  logic            div_ready;
  mul_t            mul_next;
  div_t            div_next;
  dmdb_pkg::pre_t  pre_next;

  logic signed [dmdb_pkg::PERIOD_BITS:0] span;

  // each stage takes a beat when it is empty or its content moves on
  assign div_ready  = !div_v || pre_ready;
  assign mul_ready  = !mul_v || div_ready;
  assign in_ready   = !in_v || mul_ready;
  assign poll_stall = !in_ready;

  function automatic logic [dmdb_pkg::PERIOD_BITS-1:0] period_of(
    input logic signed [PROD_BITS-1:0]        prod,
    input logic [dmdb_pkg::PERIOD_BITS-1:0]   max_ms
  );
    logic [PROD_BITS-1:0]             mag;
    logic [dmdb_pkg::PERIOD_BITS:0]   q;
    logic [dmdb_pkg::PERIOD_BITS:0]   p;
    mag = prod[PROD_BITS-1] ? PROD_BITS'(-prod) : PROD_BITS'(prod);
    q   = dmdb_pkg::div_sample_max(mag[dmdb_pkg::QUOT_IN_BITS-1:0]);
    // quotient truncates toward zero; result stays between min and max
    p   = prod[PROD_BITS-1] ? ({1'b0, max_ms} - q) : ({1'b0, max_ms} + q);
    return p[dmdb_pkg::PERIOD_BITS-1:0];
  endfunction

  function automatic logic [dmdb_pkg::DUTY_BITS-1:0] duty_of(
    input logic [dmdb_pkg::SAMPLE_BITS-1:0] s
  );
    logic [DPROD_BITS-1:0]            dp;
    logic [dmdb_pkg::PERIOD_BITS:0]   q;
    dp = {s, {dmdb_pkg::DUTY_BITS{1'b0}}} - DPROD_BITS'(s);
    q  = dmdb_pkg::div_sample_max(dmdb_pkg::QUOT_IN_BITS'(dp));
    if (q > (dmdb_pkg::PERIOD_BITS + 1)'(dmdb_pkg::DUTY_MAX)) begin
      q = (dmdb_pkg::PERIOD_BITS + 1)'(dmdb_pkg::DUTY_MAX);
    end
    return q[dmdb_pkg::DUTY_BITS-1:0];
  endfunction

  always_comb begin
    span = $signed({1'b0, cfg.min_period_ms}) - $signed({1'b0, cfg.max_period_ms});
    mul_next.now_us       = in_q.now_us;
    mul_next.button_level = in_q.button_level;
    mul_next.pot_sample   = in_q.pot_sample;
    mul_next.light_sample = in_q.light_sample;
    mul_next.prod_pot     = PROD_BITS'($signed({1'b0, in_q.pot_sample}) * span);
    mul_next.prod_light   = PROD_BITS'($signed({1'b0, in_q.light_sample}) * span);
  end

  always_comb begin
    div_next.now_us       = mul_q.now_us;
    div_next.button_level = mul_q.button_level;
    div_next.pot_sample   = mul_q.pot_sample;
    div_next.light_sample = mul_q.light_sample;
    div_next.duty_pot     = duty_of(mul_q.pot_sample);
    div_next.duty_light   = duty_of(mul_q.light_sample);
    div_next.period_pot   = period_of(mul_q.prod_pot, cfg.max_period_ms);
    div_next.period_light = period_of(mul_q.prod_light, cfg.max_period_ms);
  end

  always_comb begin
    pre_next.now_us       = div_q.now_us;
    pre_next.button_level = div_q.button_level;
    pre_next.pot_sample   = div_q.pot_sample;
    pre_next.light_sample = div_q.light_sample;
    pre_next.duty_pot     = div_q.duty_pot;
    pre_next.duty_light   = div_q.duty_light;
    // period in ms to half period in us
    pre_next.half_pot     = dmdb_pkg::HALF_BITS'(div_q.period_pot)
                          * dmdb_pkg::HALF_BITS'(dmdb_pkg::HALF_SCALE);
    pre_next.half_light   = dmdb_pkg::HALF_BITS'(div_q.period_light)
                          * dmdb_pkg::HALF_BITS'(dmdb_pkg::HALF_SCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v  <= 1'b0;
      mul_v <= 1'b0;
      div_v <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v <= poll_valid;
      end
      if (mul_ready) begin
        mul_v <= in_v;
      end
      if (div_ready) begin
        div_v <= mul_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_q <= poll;
    end
    if (mul_ready) begin
      mul_q <= mul_next;
    end
    if (div_ready) begin
      div_q <= div_next;
    end
  end

  assign pre_valid = div_v;
  assign pre       = pre_next;

endmodule

// File: design/dmdb_ctrl.sv
module dmdb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  dmdb_pkg::cfg_t    cfg,
  input  logic              pre_valid,
  output logic              pre_ready,
  input  dmdb_pkg::pre_t    pre,
  output logic              result_valid,
  input  logic              result_stall,
  output dmdb_pkg::result_t result
);

  logic                            accepted_button_level;
  logic [dmdb_pkg::TIME_WIDTH-1:0] last_button_change_time;
  logic                            current_mode;
  logic                            blink_state;
  logic [dmdb_pkg::TIME_WIDTH-1:0] last_toggle_time;

  logic                            take;
  logic [dmdb_pkg::TIME_WIDTH-1:0] btn_elapsed;
  logic [dmdb_pkg::TIME_WIDTH-1:0] blink_elapsed;
  logic                            btn_change;
  logic                            mode_next;
  logic                            toggle;
  dmdb_pkg::result_t               result_next;

  assign pre_ready = !result_valid || !result_stall;
  assign take      = pre_valid && pre_ready;

  always_comb begin
    btn_elapsed   = pre.now_us - last_button_change_time;
    blink_elapsed = pre.now_us - last_toggle_time;
    btn_change    = (pre.button_level != accepted_button_level)
                 && (btn_elapsed > dmdb_pkg::TIME_WIDTH'(cfg.debounce_time));
    // accepted press flips the mode
    mode_next     = current_mode ^ (btn_change && !pre.button_level);
    // compare against both half periods, pick by the updated mode
    toggle        = mode_next
                  ? (blink_elapsed >= dmdb_pkg::TIME_WIDTH'(pre.half_light))
                  : (blink_elapsed >= dmdb_pkg::TIME_WIDTH'(pre.half_pot));
    result_next.duty            = mode_next ? pre.duty_light : pre.duty_pot;
    result_next.blink_level     = blink_state ^ toggle;
    result_next.mode            = mode_next;
    result_next.selected_sample = mode_next ? pre.light_sample : pre.pot_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_button_level   <= 1'b1;
      last_button_change_time <= '0;
      current_mode            <= 1'b0;
      blink_state             <= 1'b0;
      last_toggle_time        <= '0;
      result_valid            <= 1'b0;
    end else begin
      if (pre_ready) begin
        result_valid <= pre_valid;
      end
      if (take) begin
        if (btn_change) begin
          accepted_button_level   <= pre.button_level;
          last_button_change_time <= pre.now_us;
        end
        current_mode <= mode_next;
        if (toggle) begin
          blink_state      <= ~blink_state;
          last_toggle_time <= pre.now_us;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

endmodule
